// File: sv/multi_button_click_detector_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the multi-button click detector
// Concurrent checks that simulation keeps and synthesis drops.
// ---------------------------------------------------------------------------
`ifndef MULTI_BUTTON_CLICK_DETECTOR_ASSERT_SVH
`define MULTI_BUTTON_CLICK_DETECTOR_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication, quiet while reset is asserted
`define MBCD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mbcd check failed");

// Next-cycle implication, quiet while reset is asserted
`define MBCD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mbcd check failed");

`else

`define MBCD_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define MBCD_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// File: sv/mbcd_pkg.sv
// ---------------------------------------------------------------------------
// mbcd_pkg
// Types and constants of the multi-button click detector.
// ---------------------------------------------------------------------------
package mbcd_pkg;

    // Buttons reachable through the 3-bit index of a level update
    localparam int ADDR_BUTTONS = 8;

    localparam logic [15:0] DEBOUNCE_RESET = 16'd30;
    localparam logic [15:0] WINDOW_RESET   = 16'd350;

    // Register index, taken from paddr[2]
    localparam logic REG_DEBOUNCE = 1'b0;
    localparam logic REG_WINDOW   = 1'b1;

    // Input kind and click type codes
    localparam logic KIND_LEVEL   = 1'b0;
    localparam logic KIND_TICK    = 1'b1;
    localparam logic CLICK_SINGLE = 1'b0;
    localparam logic CLICK_DOUBLE = 1'b1;

    typedef enum logic [2:0] {
        SEQ_IDLE = 3'b001,
        SEQ_WALK = 3'b010,
        SEQ_EMIT = 3'b100
    } seq_state_t;

    typedef enum logic [4:0] {
        BTN_IDLE     = 5'b00001,
        BTN_DEBOUNCE = 5'b00010,
        BTN_DOWN     = 5'b00100,
        BTN_UP_WAIT  = 5'b01000,
        BTN_DBL_DEB  = 5'b10000
    } btn_state_t;

endpackage

// File: sv/multi_button_click_detector.sv
// ---------------------------------------------------------------------------
// multi_button_click_detector
// Debounce and single/double click detection for a bank of pushbuttons.
// ---------------------------------------------------------------------------
// Each button runs a five-state machine (idle, debounce, down, up-wait,
// second-press debounce) with a 16-bit millisecond countdown. A level update
// (tuser = 0) is applied in the cycle it is accepted; when a release during
// the second-press debounce yields a double click, that click is then handed
// to the output register once it is free. A tick (tuser = 1) is accepted and
// then walks the min(NUM_BUTTONS, 8) stored buttons one per cycle through a
// single shared subtract-and-compare unit, and hands each click it produces
// to the output register while the output side keeps up.
// Only buttons 0 to 7 can be addressed; any further buttons stay idle and are
// not stored. Clicks of one tick leave in button order and the final one
// carries tlast. The input side is not ready while a tick is walked or clicks
// are being handed over; a finished click may wait in the output register
// while the next request is taken. Debounce time lies at address 0 and the
// double-click window at address 4; write them only while the block is idle.
// ---------------------------------------------------------------------------
`include "multi_button_click_detector_assert.svh"

module multi_button_click_detector #(
    parameter int NUM_BUTTONS = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    // request in
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // [2:0] button_index, [3] level, [19:4] elapsed_ms
    input  logic        s_axis_tuser,   // [0] kind
    // clicks out
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [2:0] button_id
    output logic        m_axis_tuser,   // [0] click_type
    output logic        m_axis_tlast,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import mbcd_pkg::*;

    localparam int NB    = (NUM_BUTTONS < ADDR_BUTTONS) ? NUM_BUTTONS : ADDR_BUTTONS;
    localparam int IDX_W = (NB > 1) ? $clog2(NB) : 1;

    // configuration registers
    logic [15:0] debounce_reg;
    logic [15:0] window_reg;

    // per-button state
    btn_state_t  bstate_reg [NB];
    logic [15:0] cd_reg     [NB];

    // sequencer
    seq_state_t       seq_reg, seq_next;
    logic [IDX_W-1:0] walk_reg;
    logic [15:0]      elapsed_reg;
    logic [NB-1:0]    ev_mask_reg, ev_mask_next;
    logic [NB-1:0]    ev_type_reg, ev_type_next;

    // output register
    logic       out_valid_reg;
    logic [2:0] out_id_reg;
    logic       out_type_reg;
    logic       out_last_reg;

    // input fields
    logic [2:0]  in_idx;
    logic        in_level;
    logic [15:0] in_elapsed;
    logic        in_kind;
    logic        in_accept;
    logic        cfg_write;

    // shared unit and state write port
    logic [IDX_W-1:0] cur_idx;
    btn_state_t       cur_state;
    logic [15:0]      cur_cd;
    logic [16:0]      diff;
    logic             expired;
    logic             wr_en;
    btn_state_t       wr_state;
    logic [15:0]      wr_cd;
    logic             ev_set;
    logic             ev_kind;
    logic             upd_ok;

    // emit selection
    logic [IDX_W-1:0] sel_idx;
    logic [NB-1:0]    rest_mask;
    logic             out_load;

    assign in_idx     = s_axis_tdata[2:0];
    assign in_level   = s_axis_tdata[3];
    assign in_elapsed = s_axis_tdata[19:4];
    assign in_kind    = s_axis_tuser;

    assign s_axis_tready = (seq_reg == SEQ_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign prdata    = (paddr[2] == REG_WINDOW) ? {16'b0, window_reg} : {16'b0, debounce_reg};

    assign upd_ok  = (int'(in_idx) < NB);
    assign cur_idx = (seq_reg == SEQ_WALK) ? walk_reg : in_idx[IDX_W-1:0];

    always_comb
    begin
        cur_state = BTN_IDLE;
        cur_cd    = '0;
        if (int'(cur_idx) < NB)
        begin
            cur_state = bstate_reg[cur_idx];
            cur_cd    = cd_reg[cur_idx];
        end
    end

    // shared subtract: countdown minus elapsed, run out when not positive
    assign diff    = {1'b0, cur_cd} - {1'b0, elapsed_reg};
    assign expired = diff[16] || (diff[15:0] == 16'd0);

    always_comb
    begin
        wr_en    = 1'b0;
        wr_state = cur_state;
        wr_cd    = cur_cd;
        ev_set   = 1'b0;
        ev_kind  = CLICK_SINGLE;
        if (in_accept && (in_kind == KIND_LEVEL) && upd_ok)
        begin
            unique case (cur_state)
                BTN_IDLE:
                begin
                    if (in_level)
                    begin
                        wr_en = 1'b1; wr_state = BTN_DEBOUNCE; wr_cd = debounce_reg;
                    end
                end
                BTN_DEBOUNCE:
                begin
                    if (!in_level)
                    begin
                        wr_en = 1'b1; wr_state = BTN_IDLE; wr_cd = '0;
                    end
                end
                BTN_DOWN:
                begin
                    if (!in_level)
                    begin
                        wr_en = 1'b1; wr_state = BTN_UP_WAIT; wr_cd = window_reg;
                    end
                end
                BTN_UP_WAIT:
                begin
                    if (in_level)
                    begin
                        wr_en = 1'b1; wr_state = BTN_DBL_DEB; wr_cd = debounce_reg;
                    end
                end
                BTN_DBL_DEB:
                begin
                    if (!in_level)
                    begin
                        wr_en = 1'b1; wr_state = BTN_IDLE; wr_cd = '0;
                        ev_set = 1'b1; ev_kind = CLICK_DOUBLE;
                    end
                end
                default:
                begin
                    wr_en = 1'b1; wr_state = BTN_IDLE; wr_cd = '0;
                end
            endcase
        end
        else if ((seq_reg == SEQ_WALK) && (cur_cd != 16'd0))
        begin
            wr_en = 1'b1;
            if (expired)
            begin
                wr_cd = '0;
                unique case (cur_state)
                    BTN_DEBOUNCE: wr_state = BTN_DOWN;
                    BTN_UP_WAIT:
                    begin
                        wr_state = BTN_IDLE; ev_set = 1'b1; ev_kind = CLICK_SINGLE;
                    end
                    BTN_DBL_DEB:
                    begin
                        wr_state = BTN_IDLE; ev_set = 1'b1; ev_kind = CLICK_DOUBLE;
                    end
                    default: wr_state = BTN_IDLE;
                endcase
            end
            else
            begin
                wr_cd = diff[15:0];
            end
        end
    end

    // pick the lowest pending click; last when nothing remains behind it
    always_comb
    begin
        sel_idx = '0;
        for (int i = NB - 1; i >= 0; i--)
        begin
            if (ev_mask_reg[i])
            begin
                sel_idx = IDX_W'(i);
            end
        end
        for (int i = 0; i < NB; i++)
        begin
            rest_mask[i] = ev_mask_reg[i] && (IDX_W'(i) != sel_idx);
        end
    end

    assign out_load = (seq_reg == SEQ_EMIT) && (!out_valid_reg || m_axis_tready);

    always_comb
    begin
        seq_next     = seq_reg;
        ev_mask_next = ev_mask_reg;
        ev_type_next = ev_type_reg;
        if (ev_set)
        begin
            ev_mask_next[cur_idx] = 1'b1;
            ev_type_next[cur_idx] = ev_kind;
        end
        unique case (seq_reg)
            SEQ_IDLE:
            begin
                if (in_accept)
                begin
                    if (in_kind == KIND_TICK)
                    begin
                        seq_next = SEQ_WALK;
                    end
                    else if (ev_set)
                    begin
                        seq_next = SEQ_EMIT;
                    end
                end
            end
            SEQ_WALK:
            begin
                if (walk_reg == IDX_W'(NB - 1))
                begin
                    seq_next = ((ev_mask_reg != '0) || ev_set) ? SEQ_EMIT : SEQ_IDLE;
                end
            end
            SEQ_EMIT:
            begin
                if (out_load)
                begin
                    ev_mask_next = rest_mask;
                    if (rest_mask == '0)
                    begin
                        seq_next = SEQ_IDLE;
                    end
                end
            end
            default: seq_next = SEQ_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg <= DEBOUNCE_RESET;
            window_reg   <= WINDOW_RESET;
        end
        else if (cfg_write)
        begin
            if (paddr[2] == REG_DEBOUNCE)
            begin
                debounce_reg <= pwdata[15:0];
            end
            else
            begin
                window_reg <= pwdata[15:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NB; i++)
            begin
                bstate_reg[i] <= BTN_IDLE;
                cd_reg[i]     <= '0;
            end
        end
        else if (wr_en)
        begin
            bstate_reg[cur_idx] <= wr_state;
            cd_reg[cur_idx]     <= wr_cd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_reg     <= SEQ_IDLE;
            walk_reg    <= '0;
            ev_mask_reg <= '0;
        end
        else
        begin
            seq_reg     <= seq_next;
            ev_mask_reg <= ev_mask_next;
            if (seq_reg == SEQ_WALK)
            begin
                walk_reg <= walk_reg + IDX_W'(1);
            end
            else
            begin
                walk_reg <= '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        ev_type_reg <= ev_type_next;
        if (in_accept)
        begin
            elapsed_reg <= in_elapsed;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_id_reg   <= 3'(sel_idx);
            out_type_reg <= ev_type_reg[sel_idx];
            out_last_reg <= (rest_mask == '0);
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {5'b0, out_id_reg};
    assign m_axis_tuser  = out_type_reg;
    assign m_axis_tlast  = out_last_reg;

    // hand-over never runs with nothing pending
    `MBCD_ASSERT_NOW(a_emit_pending, clk, rst_n, seq_reg == SEQ_EMIT, ev_mask_reg != '0)
    // an accepted tick always starts a walk
    `MBCD_ASSERT_NEXT(a_tick_walks, clk, rst_n, in_accept && (in_kind == KIND_TICK),
                      seq_reg == SEQ_WALK)
    // the walk index stays on stored buttons
    `MBCD_ASSERT_NOW(a_walk_range, clk, rst_n, seq_reg == SEQ_WALK,
                     int'(walk_reg) < NB)

endmodule
